// ===== src/roll_rate_thruster_pwm_defines.svh =====
// assertion macros for the roll-rate thruster pwm block
// no dependencies; included by the top level only
`ifndef ROLL_RATE_THRUSTER_PWM_DEFINES_SVH
`define ROLL_RATE_THRUSTER_PWM_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrt check failed: same-cycle implication");

`define RRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrt check failed: next-cycle implication");

`else

`define RRT_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define RRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/rrt_pkg.sv =====
// shared types, constants and register codes for the roll-rate thruster pwm block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrt_pkg;

    localparam int unsigned RATE_SCALE  = 7528;
    localparam int unsigned RECIP_SHIFT = 44;
    localparam logic [31:0] RATE_RECIP  =
        32'((64'd1 << RECIP_SHIFT) / 64'(RATE_SCALE));
    localparam logic [16:0] FULL_DUTY   = 17'h10000;
    localparam logic [16:0] DUTY_SAT    = 17'h1FFFF;

    localparam logic [14:0] DEADBAND_RESET  = 15'd603;
    localparam logic [15:0] GAIN_RESET      = 16'd27525;
    localparam logic [15:0] MIN_DUTY_RESET  = 16'd4915;
    localparam logic [15:0] PERIOD_RESET    = 16'd200;
    localparam logic [31:0] RUN_LIMIT_RESET = 32'd15000;

    typedef enum logic [2:0] {
        REG_DEADBAND  = 3'd0,
        REG_GAIN      = 3'd1,
        REG_MIN_DUTY  = 3'd2,
        REG_PERIOD    = 3'd3,
        REG_RUN_LIMIT = 3'd4
    } rrt_reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECIP,
        ST_CORR,
        ST_UPDATE
    } rrt_state_t;

    typedef struct packed {
        logic signed [15:0] gyro_sample;
        logic [31:0]        now_ms;
    } rrt_in_t;

    typedef struct packed {
        logic        drive_cw;
        logic        drive_ccw;
        logic        armed;
        logic [16:0] duty_q16;
    } rrt_out_t;

    typedef struct packed {
        logic [14:0] deadband_counts;
        logic [15:0] gain_q16;
        logic [15:0] min_duty_q16;
        logic [15:0] period_ms;
        logic [31:0] run_limit_ms;
    } rrt_cfg_t;

    typedef struct packed {
        logic load;
        logic recip;
        logic corr;
        logic finish;
    } rrt_cmd_t;

    typedef struct packed {
        logic out_free;
    } rrt_status_t;

endpackage

`default_nettype wire

// ===== src/rrt_ctrl.sv =====
// controller state machine: sequences accept, reciprocal multiply, correction, pwm update
// depends on rrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrt_ctrl
    import rrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    output logic             sample_ready,
    input  wire rrt_status_t status,
    output rrt_cmd_t         cmd
);

    rrt_state_t state_reg;
    rrt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sample_ready = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                cmd.corr   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold until the result register can take the request
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/rrt_datapath.sv =====
// datapath: duty computation, pwm state and result register
// depends on rrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrt_datapath
    import rrt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire rrt_cfg_t cfg,
    input  wire rrt_in_t  sample,
    input  wire rrt_cmd_t cmd,
    output rrt_status_t   status,
    output logic          result_valid,
    input  wire logic     result_ready,
    output rrt_out_t      result
);

    logic [15:0] mag;
    logic [31:0] prod_full;
    logic [62:0] recip_prod;
    logic [31:0] q0_times_scale;
    logic [31:0] rem;
    logic [18:0] quot;
    logic [16:0] duty_sat;

    logic [31:0] now_reg;
    logic        neg_reg;
    logic        band_reg;
    logic        armed_reg;
    logic [30:0] prod_reg;
    logic [18:0] q0_reg;
    logic [16:0] duty_reg;

    logic        level_reg;
    logic        level_next;
    logic [31:0] last_toggle_reg;
    logic [31:0] last_toggle_next;
    logic [15:0] interval_reg;
    logic [15:0] interval_next;

    logic        result_valid_reg;
    rrt_out_t    result_reg;

    logic        active;
    logic        full_on;
    logic        below_min;
    logic [31:0] elapsed;
    logic        expired;
    logic [16:0] frac;
    logic [32:0] ival_prod;

    // magnitude and gain product straight off the accepted request
    assign mag       = sample.gyro_sample[15] ? 16'(~sample.gyro_sample + 16'sd1)
                                              : 16'(sample.gyro_sample);
    assign prod_full = 32'(mag) * 32'(cfg.gain_q16);

    // divide by the rate scale: reciprocal estimate, then one-step correction
    assign recip_prod     = 63'(prod_reg) * 63'(RATE_RECIP);
    assign q0_times_scale = 32'(q0_reg) * 32'(RATE_SCALE);
    assign rem            = 32'(prod_reg) - q0_times_scale;
    assign quot           = (rem >= 32'(RATE_SCALE)) ? q0_reg + 19'd1 : q0_reg;
    assign duty_sat       = (quot > 19'(DUTY_SAT)) ? DUTY_SAT : quot[16:0];

    // pwm update
    assign active    = armed_reg && band_reg;
    assign full_on   = duty_reg[16];
    assign below_min = duty_reg < {1'b0, cfg.min_duty_q16};
    assign elapsed   = now_reg - last_toggle_reg;
    assign expired   = elapsed >= {16'd0, interval_reg};
    assign frac      = level_reg ? (FULL_DUTY - duty_reg) : duty_reg;
    assign ival_prod = 33'(frac) * 33'(cfg.period_ms);

    always_comb
    begin
        level_next       = level_reg;
        last_toggle_next = last_toggle_reg;
        interval_next    = interval_reg;
        if (active)
        begin
            if (full_on)
            begin
                level_next = 1'b1;
            end
            else if (below_min)
            begin
                level_next = 1'b0;
            end
            else if (expired)
            begin
                level_next       = ~level_reg;
                last_toggle_next = now_reg;
                interval_next    = ival_prod[31:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg   <= sample.now_ms;
            neg_reg   <= sample.gyro_sample[15];
            band_reg  <= mag >= {1'b0, cfg.deadband_counts};
            armed_reg <= sample.now_ms < cfg.run_limit_ms;
            prod_reg  <= prod_full[30:0];
        end
        if (cmd.recip)
        begin
            q0_reg <= recip_prod[RECIP_SHIFT +: 19];
        end
        if (cmd.corr)
        begin
            duty_reg <= armed_reg ? duty_sat : 17'd0;
        end
        if (cmd.finish)
        begin
            result_reg.drive_cw  <= active && !neg_reg && level_next;
            result_reg.drive_ccw <= active && neg_reg && level_next;
            result_reg.armed     <= armed_reg;
            result_reg.duty_q16  <= duty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg        <= 1'b0;
            last_toggle_reg  <= '0;
            interval_reg     <= PERIOD_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                level_reg       <= level_next;
                last_toggle_reg <= last_toggle_next;
                interval_reg    <= interval_next;
            end
            if (cmd.finish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !result_valid_reg || result_ready;
    assign result_valid    = result_valid_reg;
    assign result          = result_reg;

endmodule

`default_nettype wire

// ===== src/roll_rate_thruster_pwm.sv =====
// top level: configuration registers, controller and datapath of the roll-rate thruster pwm
// depends on rrt_pkg, rrt_ctrl, rrt_datapath and roll_rate_thruster_pwm_defines.svh
//
//  channel   handshake                     payload
//  sample    sample_valid / sample_ready   sample (gyro_sample, now_ms)
//  result    result_valid / result_ready   result (drive_cw, drive_ccw, armed, duty_q16)
//  config    cfg_we                        cfg_index, cfg_data
//
// per item: accept with |sample| * gain, reciprocal multiply by 1/7528,
// remainder correction and saturation, pwm update with the interval multiply
// the four multiplies fall in separate steps of the controller, one item in flight
// reset restores config, controller state, pwm state and result_valid; no clearing pass
// a result not taken holds the pwm update step; no new sample is taken until it completes
`timescale 1ns / 1ps
`default_nettype none
`include "roll_rate_thruster_pwm_defines.svh"

module roll_rate_thruster_pwm
    import rrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    output logic             sample_ready,
    input  wire rrt_in_t     sample,
    output logic             result_valid,
    input  wire logic        result_ready,
    output rrt_out_t         result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    rrt_cfg_t    cfg_reg;
    rrt_cmd_t    cmd;
    rrt_status_t status;

    logic        disarmed_out;
    logic        quiet_out;
    logic        both_drives;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband_counts <= DEADBAND_RESET;
            cfg_reg.gain_q16        <= GAIN_RESET;
            cfg_reg.min_duty_q16    <= MIN_DUTY_RESET;
            cfg_reg.period_ms       <= PERIOD_RESET;
            cfg_reg.run_limit_ms    <= RUN_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (rrt_reg_idx_t'(cfg_index))
                REG_DEADBAND:  cfg_reg.deadband_counts <= cfg_data[14:0];
                REG_GAIN:      cfg_reg.gain_q16        <= cfg_data[15:0];
                REG_MIN_DUTY:  cfg_reg.min_duty_q16    <= cfg_data[15:0];
                REG_PERIOD:    cfg_reg.period_ms       <= cfg_data[15:0];
                REG_RUN_LIMIT: cfg_reg.run_limit_ms    <= cfg_data;
                default:       ;
            endcase
        end
    end

    rrt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    rrt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign disarmed_out = result_valid && !result.armed;
    assign quiet_out    = !result.drive_cw && !result.drive_ccw && (result.duty_q16 == 17'd0);
    assign both_drives  = result.drive_cw && result.drive_ccw;

    `RRT_ASSERT_SAME(a_disarmed_quiet, clk, rst_n, disarmed_out, quiet_out)

    `RRT_ASSERT_SAME(a_one_side_only, clk, rst_n, result_valid, !both_drives)

    `RRT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample_valid && sample_ready, !sample_ready)

endmodule

`default_nettype wire
